>>> sv/grid_cell_owner_lookup_assert.svh
// Assertion macros for the grid cell owner lookup checker.
// Each macro samples on clk; the reset-qualified forms are disabled while rst is high.
`ifndef GRID_CELL_OWNER_LOOKUP_ASSERT_SVH
`define GRID_CELL_OWNER_LOOKUP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define GCOL_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("grid cell owner lookup: assertion failed");

// next-cycle implication, disabled during reset
`define GCOL_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("grid cell owner lookup: assertion failed");

// next-cycle implication, also checked during reset
`define GCOL_ASSERT_NXT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("grid cell owner lookup: assertion failed");

`endif

>>> sv/gcol_pkg.sv
// Shared types, register codes and helpers for the grid cell owner lookup.
// No dependencies; used by gcol_axis and grid_cell_owner_lookup.
package gcol_pkg;

  localparam int MAX_ROWS_DEF = 16;
  localparam int MAX_COLS_DEF = 16;

  localparam int EXT_W    = 31;
  localparam int POS_W    = 32;
  localparam int BOUND_W  = 33;
  localparam int ID_W     = 16;
  localparam int ID_CNT_W = 17;
  localparam int CFG_CNT_W = 5;
  localparam int CLAMP_W  = 7;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;
  localparam int REG_IDX_W = 3;
  localparam int OUT_IDX_W = 4;

  typedef logic signed [BOUND_W-1:0] bound_t;

  localparam logic [REG_IDX_W-1:0] REG_GRID_ROWS      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_GRID_COLS      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_WORLD_WIDTH    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_WORLD_HEIGHT   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_FIRST_WORKER   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_LAST_WORKER    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_LOCAL_WORKER   = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_STRATEGY_READY = 3'd7;

  localparam logic [CFG_CNT_W-1:0] GRID_ROWS_RST    = 5'd1;
  localparam logic [CFG_CNT_W-1:0] GRID_COLS_RST    = 5'd1;
  localparam logic [EXT_W-1:0]     WORLD_WIDTH_RST  = 31'd256000000;
  localparam logic [EXT_W-1:0]     WORLD_HEIGHT_RST = 31'd256000000;

  function automatic logic [CLAMP_W-1:0] clamp_count(logic [CFG_CNT_W-1:0] v,
                                                     int unsigned maxv);
    logic [CLAMP_W-1:0] r;
    if (v == '0) begin
      r = CLAMP_W'(1);
    end else if (32'(v) > maxv) begin
      r = CLAMP_W'(maxv);
    end else begin
      r = CLAMP_W'(v);
    end
    return r;
  endfunction

endpackage

>>> sv/grid_cell_owner_lookup.sv
// Grid cell owner lookup: maps a Q23.8 position to its grid cell and owning worker.
// Input register, then result register; one transfer per cycle sustained while out_ready is high.
// Boundaries are rebuilt after reset and after every register write, by the 31-step serial
// divider and then one boundary per cycle; in_ready is low meanwhile and during a write.
// Synchronous active-high reset clears registers to defaults and empties the pipeline.
// Uses gcol_pkg and gcol_axis.
module grid_cell_owner_lookup #(
  parameter int MAX_ROWS = gcol_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = gcol_pkg::MAX_COLS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gcol_pkg::ADDR_W-1:0]   paddr,
  input  logic [gcol_pkg::DATA_W-1:0]   pwdata,
  output logic [gcol_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [gcol_pkg::POS_W-1:0] pos_x,
  input  logic signed [gcol_pkg::POS_W-1:0] pos_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          owner_valid,
  output logic [gcol_pkg::ID_W-1:0]     owner_worker_id,
  output logic [gcol_pkg::OUT_IDX_W-1:0] cell_row,
  output logic [gcol_pkg::OUT_IDX_W-1:0] cell_col,
  output logic                          local_owns
);
  import gcol_pkg::*;

  localparam int RC_W   = $clog2(MAX_ROWS + 1);
  localparam int CC_W   = $clog2(MAX_COLS + 1);
  localparam int CELL_W = $clog2(MAX_ROWS * MAX_COLS + 1);

  logic [CFG_CNT_W-1:0] grid_rows;
  logic [CFG_CNT_W-1:0] grid_cols;
  logic [EXT_W-1:0]     world_width;
  logic [EXT_W-1:0]     world_height;
  logic [ID_W-1:0]      first_worker_id;
  logic [ID_W-1:0]      last_worker_id;
  logic [ID_W-1:0]      local_worker_id;
  logic                 strategy_ready;

  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] cfg_idx;

  logic [RC_W-1:0]      rows;
  logic [CC_W-1:0]      cols;
  logic                 row_busy;
  logic                 col_busy;
  bound_t               row_b [MAX_ROWS+1];
  bound_t               col_b [MAX_COLS+1];

  logic                 s1_valid;
  logic signed [POS_W-1:0] s1_x;
  logic signed [POS_W-1:0] s1_y;
  logic                 s1_free;
  logic                 s2_en;

  logic [RC_W-1:0]      ridx;
  logic [CC_W-1:0]      cidx;
  logic                 in_row;
  logic                 in_col;
  logic [CELL_W-1:0]    cell_idx;
  logic [CELL_W-1:0]    cells;
  logic [ID_CNT_W-1:0]  ids;
  logic [ID_W-1:0]      lidx;
  logic                 in_world;
  logic                 hit_valid;
  logic                 hit_local;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows       <= GRID_ROWS_RST;
      grid_cols       <= GRID_COLS_RST;
      world_width     <= WORLD_WIDTH_RST;
      world_height    <= WORLD_HEIGHT_RST;
      first_worker_id <= '0;
      last_worker_id  <= '0;
      local_worker_id <= '0;
      strategy_ready  <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_GRID_ROWS:      grid_rows       <= pwdata[CFG_CNT_W-1:0];
        REG_GRID_COLS:      grid_cols       <= pwdata[CFG_CNT_W-1:0];
        REG_WORLD_WIDTH:    world_width     <= pwdata[EXT_W-1:0];
        REG_WORLD_HEIGHT:   world_height    <= pwdata[EXT_W-1:0];
        REG_FIRST_WORKER:   first_worker_id <= pwdata[ID_W-1:0];
        REG_LAST_WORKER:    last_worker_id  <= pwdata[ID_W-1:0];
        REG_LOCAL_WORKER:   local_worker_id <= pwdata[ID_W-1:0];
        REG_STRATEGY_READY: strategy_ready  <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_GRID_ROWS:      prdata = DATA_W'(grid_rows);
      REG_GRID_COLS:      prdata = DATA_W'(grid_cols);
      REG_WORLD_WIDTH:    prdata = DATA_W'(world_width);
      REG_WORLD_HEIGHT:   prdata = DATA_W'(world_height);
      REG_FIRST_WORKER:   prdata = DATA_W'(first_worker_id);
      REG_LAST_WORKER:    prdata = DATA_W'(last_worker_id);
      REG_LOCAL_WORKER:   prdata = DATA_W'(local_worker_id);
      REG_STRATEGY_READY: prdata = DATA_W'(strategy_ready);
    endcase
  end

  assign rows = RC_W'(clamp_count(grid_rows, MAX_ROWS));
  assign cols = CC_W'(clamp_count(grid_cols, MAX_COLS));

  gcol_axis #(.MAX_N(MAX_ROWS)) u_row_axis (
    .clk    (clk),
    .rst    (rst),
    .start  (cfg_wr),
    .n      (rows),
    .extent (world_height),
    .busy   (row_busy),
    .bounds (row_b)
  );

  gcol_axis #(.MAX_N(MAX_COLS)) u_col_axis (
    .clk    (clk),
    .rst    (rst),
    .start  (cfg_wr),
    .n      (cols),
    .extent (world_width),
    .busy   (col_busy),
    .bounds (col_b)
  );

  assign s2_en    = ~out_valid | out_ready;
  assign s1_free  = ~s1_valid | s2_en;
  assign in_ready = s1_free & ~row_busy & ~col_busy & ~cfg_wr;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= in_valid & in_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid & in_ready) begin
      s1_x <= pos_x;
      s1_y <= pos_y;
    end
  end

  always_comb begin
    bound_t px;
    logic   ge_now;
    logic   ge_nxt;
    px     = bound_t'(s1_x);
    ridx   = '0;
    in_row = 1'b0;
    for (int k = 0; k < MAX_ROWS; k++) begin
      ge_now = px >= row_b[k];
      ge_nxt = px >= row_b[k+1];
      if (ge_now && !ge_nxt && (RC_W'(k) < rows)) begin
        ridx   = ridx | RC_W'(k);
        in_row = 1'b1;
      end
    end
  end

  always_comb begin
    bound_t py;
    logic   ge_now;
    logic   ge_nxt;
    py     = bound_t'(s1_y);
    cidx   = '0;
    in_col = 1'b0;
    for (int k = 0; k < MAX_COLS; k++) begin
      ge_now = py >= col_b[k];
      ge_nxt = py >= col_b[k+1];
      if (ge_now && !ge_nxt && (CC_W'(k) < cols)) begin
        cidx   = cidx | CC_W'(k);
        in_col = 1'b1;
      end
    end
  end

  assign in_world = in_row & in_col;
  assign cell_idx = CELL_W'(cidx) * CELL_W'(rows) + CELL_W'(ridx);
  assign cells    = CELL_W'(rows) * CELL_W'(cols);
  assign ids      = (last_worker_id >= first_worker_id)
                  ? ({1'b0, last_worker_id} - {1'b0, first_worker_id} + ID_CNT_W'(1))
                  : '0;
  assign lidx     = local_worker_id - first_worker_id;

  assign hit_valid = strategy_ready & in_world & (ids == ID_CNT_W'(cells));
  assign hit_local = strategy_ready & in_world
                   & (local_worker_id >= first_worker_id)
                   & (local_worker_id <= last_worker_id)
                   & ({1'b0, lidx} < ID_CNT_W'(cells))
                   & ({1'b0, lidx} == ID_CNT_W'(cell_idx));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_en) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en) begin
      owner_valid     <= hit_valid;
      owner_worker_id <= hit_valid ? first_worker_id + ID_W'(cell_idx) : '0;
      cell_row        <= hit_valid ? OUT_IDX_W'(ridx) : '0;
      cell_col        <= hit_valid ? OUT_IDX_W'(cidx) : '0;
      local_owns      <= hit_local;
    end
  end

endmodule

>>> sv/gcol_axis.sv
// Boundary generator for one grid axis: extent / count by a bit-serial divider,
// then one exact ceiling boundary per cycle by quotient/remainder stepping. Uses gcol_pkg.
module gcol_axis #(
  parameter int MAX_N = gcol_pkg::MAX_ROWS_DEF,
  localparam int CNT_W = $clog2(MAX_N + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [CNT_W-1:0]           n,
  input  logic [gcol_pkg::EXT_W-1:0] extent,
  output logic                       busy,
  output gcol_pkg::bound_t           bounds [MAX_N+1]
);
  import gcol_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_STEP = 2'd3;

  localparam int DC_W = $clog2(EXT_W);
  localparam int M_W  = CNT_W + 2;

  logic [1:0]        state;
  logic [DC_W-1:0]   dcnt;
  logic [EXT_W-1:0]  quo;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  k;
  bound_t            f;
  logic [M_W-1:0]    m;

  logic [CNT_W:0]    sh;
  logic              sh_ge;
  logic [CNT_W:0]    d2;
  logic [M_W-1:0]    m_sum;
  logic              m_wrap;
  logic [EXT_W:0]    ext_half;
  bound_t            qs;

  assign sh       = {rem, quo[EXT_W-1]};
  assign sh_ge    = sh >= {1'b0, n};
  assign d2       = {n, 1'b0};
  assign m_sum    = m + M_W'({rem, 1'b0});
  assign m_wrap   = m_sum >= M_W'(d2);
  assign ext_half = ({1'b0, extent} + (EXT_W+1)'(1)) >> 1;
  assign qs       = bound_t'({2'b00, quo});
  assign busy     = state != ST_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else if (start) begin
      state <= ST_LOAD;
    end else begin
      unique case (state)
        ST_IDLE: state <= ST_IDLE;
        ST_LOAD: state <= ST_DIV;
        ST_DIV: begin
          if (dcnt == DC_W'(EXT_W - 1)) begin
            state <= ST_STEP;
          end
        end
        ST_STEP: begin
          if (k == n) begin
            state <= ST_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        k <= k;
      end
      ST_LOAD: begin
        quo  <= extent;
        rem  <= '0;
        dcnt <= '0;
        k    <= '0;
        f    <= -$signed({2'b00, ext_half[EXT_W-1:0]});
        m    <= extent[0] ? M_W'(n) : '0;
      end
      ST_DIV: begin
        rem  <= sh_ge ? CNT_W'(sh - {1'b0, n}) : CNT_W'(sh);
        quo  <= {quo[EXT_W-2:0], sh_ge};
        dcnt <= dcnt + DC_W'(1);
      end
      ST_STEP: begin
        bounds[k] <= f + bound_t'(m != '0);
        k <= k + CNT_W'(1);
        if (m_wrap) begin
          m <= m_sum - M_W'(d2);
          f <= f + qs + bound_t'(1);
        end else begin
          m <= m_sum;
          f <= f + qs;
        end
      end
    endcase
  end

endmodule

>>> sv/gcol_checker.sv
// Port-level checker for grid_cell_owner_lookup, bound to the top level below.
// Depends on the macros in grid_cell_owner_lookup_assert.svh.
`include "grid_cell_owner_lookup_assert.svh"

module gcol_checker (
  input logic       clk,
  input logic       rst,
  input logic       psel,
  input logic       penable,
  input logic       pwrite,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       owner_valid,
  input logic [15:0] owner_worker_id,
  input logic [3:0] cell_row,
  input logic [3:0] cell_col
);

  `GCOL_ASSERT_IMP(a_invalid_zero, out_valid && !owner_valid, owner_worker_id == 16'd0 && cell_row == 4'd0 && cell_col == 4'd0)
  `GCOL_ASSERT_NXT_RST(a_reset_rebuild, rst, !in_ready)
  `GCOL_ASSERT_NXT(a_write_rebuild, psel && penable && pwrite, !in_ready)
  `GCOL_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(owner_worker_id) && $stable(cell_row) && $stable(cell_col))

endmodule

bind grid_cell_owner_lookup gcol_checker u_gcol_checker (.*);
